@@ rtl/cfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_pkg
// Types and fixed codes shared by the command frame builder modules.
// ----------------------------------------------------------------------------
package cfb_pkg;

    // Frame type bytes
    localparam logic [7:0] TYPE_PLAIN = 8'hA0;
    localparam logic [7:0] TYPE_TLS   = 8'hB0;

    // Data checksum seed and command mask
    localparam logic [7:0] CKS_SEED = 8'hAA;
    localparam logic [7:0] CMD_MASK = 8'hFE;

    // Header overhead and trailer extras
    localparam logic [15:0] PLAIN_LEN_ADD  = 16'd4;
    localparam logic [15:0] DATA_LEN_ADD   = 16'd1;
    localparam logic [16:0] TOTAL_ADD_PLAIN = 17'd8;
    localparam logic [16:0] TOTAL_ADD_TLS   = 17'd4;

    // Frame kind on the start word
    localparam logic KIND_PLAIN = 1'b0;
    localparam logic KIND_TLS   = 1'b1;

    // Input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_OUTSIDE  = 2'd2
    } t_err;

    // Header byte positions
    typedef enum logic [2:0] {
        HDR_TYPE  = 3'd0,
        HDR_LEN_L = 3'd1,
        HDR_LEN_H = 3'd2,
        HDR_SUM   = 3'd3,
        HDR_CMD   = 3'd4,
        HDR_DL_L  = 3'd5,
        HDR_DL_H  = 3'd6
    } t_hdr_idx;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HDR  = 4'b0010,
        S_CKS  = 4'b0100,
        S_PAD  = 4'b1000
    } t_phase;

endpackage

@@ rtl/cfb_hdr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_hdr
// Selects one header byte of the current frame from the latched start word.
// ----------------------------------------------------------------------------
module cfb_hdr
    import cfb_pkg::*;
(
    input  logic        i_kind,
    input  logic [7:0]  i_cmd,
    input  logic [15:0] i_len,
    input  t_hdr_idx    i_idx,
    output logic [7:0]  o_byte
);

    logic [7:0]  w_type;
    logic [15:0] w_plen;
    logic [15:0] w_dlen;
    logic [7:0]  w_hsum;

    assign w_type = (i_kind == KIND_TLS) ? TYPE_TLS : TYPE_PLAIN;
    assign w_plen = (i_kind == KIND_TLS) ? i_len : i_len + PLAIN_LEN_ADD;
    assign w_dlen = i_len + DATA_LEN_ADD;
    assign w_hsum = w_type + w_plen[7:0] + w_plen[15:8];

    always_comb begin
        unique case (i_idx)
            HDR_TYPE:  o_byte = w_type;
            HDR_LEN_L: o_byte = w_plen[7:0];
            HDR_LEN_H: o_byte = w_plen[15:8];
            HDR_SUM:   o_byte = w_hsum;
            HDR_CMD:   o_byte = i_cmd;
            HDR_DL_L:  o_byte = w_dlen[7:0];
            HDR_DL_H:  o_byte = w_dlen[15:8];
            default:   o_byte = 8'h00;
        endcase
    end

endmodule

@@ rtl/command_frame_builder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_builder_core
// Serialises outgoing link frames one byte per output word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): a start word (op 0) opens a frame
//   with kind, command byte and payload length; a data word (op 1) carries one
//   payload byte. Output channel (o_out_valid / i_out_ready) gives one link
//   byte per word with chunk_end, frame_end and an error code.
//   The first byte of a start word, or the byte of a data word, is loaded
//   into the output register on acceptance.
//   Throughput: data words run at one per cycle while the receiver keeps up.
//   A start word holds the input for the rest of its header (3 more bytes
//   TLS, 6 plain); the last data word holds it for the checksum byte (plain)
//   and the zero padding up to the next CHUNK_BYTES boundary, one byte per
//   cycle while the receiver keeps up, all through one output register.
//   A too-long start or a data word outside a frame yields one error word.
//   Reset: idle, no frame open, output empty.
//   When the receiver stalls, the output word holds and no input is taken
//   once the output register is full.
// ----------------------------------------------------------------------------
module command_frame_builder_core
    import cfb_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 4096,
    parameter int CHUNK_BYTES     = 64
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic        i_frame_kind,
    input  logic [7:0]  i_cmd_byte,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_chunk_end,
    output logic        o_frame_end,
    output logic [1:0]  o_error
);

    localparam int POS_W = $clog2(CHUNK_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CHUNK_BYTES - 1);
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
    localparam logic [16:0]      MAX_TOTAL = 17'(MAX_FRAME_BYTES);

    t_phase           r_phase, n_phase;
    logic             r_in_frame, n_in_frame;
    logic             r_kind, n_kind;
    logic [7:0]       r_cmd, n_cmd;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_left, n_left;
    logic [7:0]       r_sum, n_sum;
    logic [POS_W-1:0] r_pos, n_pos;
    t_hdr_idx         r_idx, n_idx;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_chunk_end;
    logic             r_frame_end;
    t_err             r_error;

    logic             w_adv;
    logic             w_in_fire;
    logic             w_wrap;
    logic [POS_W-1:0] w_pos_inc;
    logic [7:0]       w_hdr_byte;
    logic [16:0]      w_total;
    logic [15:0]      w_dlen;
    logic             w_hdr_last;

    logic             w_emit;
    logic [7:0]       w_byte;
    logic             w_ce;
    logic             w_fe;
    t_err             w_err;

    cfb_hdr u_hdr (
        .i_kind (r_kind),
        .i_cmd  (r_cmd),
        .i_len  (r_len),
        .i_idx  (r_idx),
        .o_byte (w_hdr_byte)
    );

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_phase == S_IDLE) && w_adv;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_wrap    = (r_pos == POS_LAST);
    assign w_pos_inc = w_wrap ? '0 : r_pos + POS_ONE;

    assign w_total = {1'b0, i_payload_length}
                   + ((i_frame_kind == KIND_TLS) ? TOTAL_ADD_TLS : TOTAL_ADD_PLAIN);
    assign w_dlen  = i_payload_length + DATA_LEN_ADD;
    assign w_hdr_last = (r_kind == KIND_TLS) ? (r_idx == HDR_SUM) : (r_idx == HDR_DL_H);

    always_comb begin
        n_phase    = r_phase;
        n_in_frame = r_in_frame;
        n_kind     = r_kind;
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_left     = r_left;
        n_sum      = r_sum;
        n_pos      = r_pos;
        n_idx      = r_idx;
        w_emit     = 1'b0;
        w_byte     = 8'h00;
        w_ce       = 1'b0;
        w_fe       = 1'b0;
        w_err      = ERR_NONE;

        unique case (r_phase)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_op == OP_START) begin
                        n_in_frame = 1'b0;
                        n_pos      = '0;
                        w_emit     = 1'b1;
                        if (w_total > MAX_TOTAL) begin
                            w_err = ERR_TOO_LONG;
                        end else begin
                            // first header byte goes out at chunk position zero
                            n_in_frame = 1'b1;
                            n_kind     = i_frame_kind;
                            n_cmd      = i_cmd_byte;
                            n_len      = i_payload_length;
                            n_left     = i_payload_length;
                            n_sum      = (i_frame_kind == KIND_TLS) ? 8'h00 :
                                         (i_cmd_byte & CMD_MASK) + w_dlen[7:0] + w_dlen[15:8];
                            w_byte     = (i_frame_kind == KIND_TLS) ? TYPE_TLS : TYPE_PLAIN;
                            n_pos      = POS_ONE;
                            n_idx      = HDR_LEN_L;
                            n_phase    = S_HDR;
                        end
                    end else if (!r_in_frame) begin
                        w_emit = 1'b1;
                        w_err  = ERR_OUTSIDE;
                    end else begin
                        w_emit = 1'b1;
                        w_byte = i_data_byte;
                        w_ce   = w_wrap;
                        n_pos  = w_pos_inc;
                        n_sum  = r_sum + i_data_byte;
                        n_left = r_left - 16'd1;
                        if (r_left == 16'd1) begin
                            if (r_kind == KIND_PLAIN) begin
                                n_phase = S_CKS;
                            end else if (w_wrap) begin
                                w_fe       = 1'b1;
                                n_in_frame = 1'b0;
                            end else begin
                                n_phase = S_PAD;
                            end
                        end
                    end
                end
            end
            S_HDR: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    w_byte = w_hdr_byte;
                    w_ce   = w_wrap;
                    n_pos  = w_pos_inc;
                    n_idx  = t_hdr_idx'(r_idx + 3'd1);
                    if (w_hdr_last) begin
                        // empty payload: finish straight after the header
                        if (r_len != 16'd0) begin
                            n_phase = S_IDLE;
                        end else if (r_kind == KIND_PLAIN) begin
                            n_phase = S_CKS;
                        end else if (w_wrap) begin
                            w_fe       = 1'b1;
                            n_in_frame = 1'b0;
                            n_phase    = S_IDLE;
                        end else begin
                            n_phase = S_PAD;
                        end
                    end
                end
            end
            S_CKS: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    w_byte = CKS_SEED - r_sum;
                    w_ce   = w_wrap;
                    n_pos  = w_pos_inc;
                    if (w_wrap) begin
                        w_fe       = 1'b1;
                        n_in_frame = 1'b0;
                        n_phase    = S_IDLE;
                    end else begin
                        n_phase = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    w_ce   = w_wrap;
                    n_pos  = w_pos_inc;
                    if (w_wrap) begin
                        w_fe       = 1'b1;
                        n_in_frame = 1'b0;
                        n_phase    = S_IDLE;
                    end
                end
            end
            default: begin
                n_phase = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= S_IDLE;
            r_in_frame  <= 1'b0;
            r_left      <= '0;
            r_sum       <= '0;
            r_pos       <= '0;
            r_idx       <= HDR_TYPE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_in_frame <= n_in_frame;
            r_left     <= n_left;
            r_sum      <= n_sum;
            r_pos      <= n_pos;
            r_idx      <= n_idx;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_cmd  <= n_cmd;
        r_len  <= n_len;
        if (w_emit) begin
            r_out_byte  <= w_byte;
            r_chunk_end <= w_ce;
            r_frame_end <= w_fe;
            r_error     <= w_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_chunk_end = r_chunk_end;
    assign o_frame_end = r_frame_end;
    assign o_error     = r_error;

endmodule
